// ----- rtl/mte_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mte_pkg
// shared types and constants for the match token emitter
// ---------------------------------------------------------------------------
package mte_pkg;

  localparam int POS_BITS = 32;
  localparam int MIN_LEN_BITS = 8;
  localparam logic [MIN_LEN_BITS-1:0] MIN_LEN_RESET = MIN_LEN_BITS'(32);

  localparam logic MODE_MATCH     = 1'b0;
  localparam logic MODE_BLOCK_END = 1'b1;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] dest_pos;
    logic [31:0] src_pos;
    logic [31:0] match_len;
    logic [31:0] block_len;
  } item_t;

  typedef struct packed {
    logic        is_block_end;
    logic [31:0] literal_start;
    logic [31:0] literal_len;
    logic [31:0] src_offset;
    logic [31:0] kept_len;
    logic [31:0] block_unmatched;
    logic [31:0] block_matched;
    logic [31:0] block_overlap;
  } token_t;

  typedef struct packed {
    pos_t cursor;
    pos_t unmatched_count;
    pos_t matched_count;
    pos_t overlap_count;
  } state_t;

endpackage

// ----- rtl/mte_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mte_step
// trims one match against the cursor and forms its token and next state
// ---------------------------------------------------------------------------
module mte_step (
  input  mte_pkg::item_t                        item,
  input  mte_pkg::state_t                       state,
  input  logic [mte_pkg::MIN_LEN_BITS-1:0]      min_len,
  output logic                                  emit,
  output mte_pkg::token_t                       token,
  output mte_pkg::state_t                       state_next
);

  always_comb begin
    mte_pkg::pos_t             d;
    mte_pkg::pos_t             s;
    mte_pkg::pos_t             len;
    mte_pkg::pos_t             blen;
    mte_pkg::pos_t             ov;
    mte_pkg::pos_t             len_kept;
    mte_pkg::pos_t             d_kept;
    mte_pkg::pos_t             s_kept;
    mte_pkg::pos_t             ov_add;
    mte_pkg::pos_t             lit;
    mte_pkg::pos_t             unm;
    logic [mte_pkg::POS_BITS:0] end_pos;
    logic                      behind;

    d    = item.dest_pos[mte_pkg::POS_BITS-1:0];
    s    = item.src_pos[mte_pkg::POS_BITS-1:0];
    len  = item.match_len[mte_pkg::POS_BITS-1:0];
    blen = item.block_len[mte_pkg::POS_BITS-1:0];

    behind = d < state.cursor;
    ov     = state.cursor - d;
    if (behind) begin
      len_kept = len - ov;
      d_kept   = state.cursor;
      s_kept   = s + ov;
      ov_add   = ov;
    end else begin
      len_kept = len;
      d_kept   = d;
      s_kept   = s;
      ov_add   = '0;
    end
    lit     = d_kept - state.cursor;
    end_pos = {1'b0, d_kept} + {1'b0, len_kept};

    emit       = 1'b0;
    token      = '0;
    state_next = state;
    unm        = '0;

    if (item.mode == mte_pkg::MODE_BLOCK_END) begin
      lit = (blen > state.cursor) ? blen - state.cursor : '0;
      unm = state.unmatched_count + lit;
      emit                  = 1'b1;
      token.is_block_end    = 1'b1;
      token.literal_start   = 32'(state.cursor);
      token.literal_len     = 32'(lit);
      token.block_unmatched = 32'(unm);
      token.block_matched   = 32'(state.matched_count);
      token.block_overlap   = 32'(state.overlap_count);
      state_next            = '0;
    end else if ((behind && ov >= len) ||
                 (len_kept < mte_pkg::POS_BITS'(min_len))) begin
      // dropped: trimmed part plus the short remainder always sum to len
      state_next.overlap_count = state.overlap_count + len;
    end else begin
      emit                       = 1'b1;
      token.literal_start        = 32'(state.cursor);
      token.literal_len          = 32'(lit);
      token.src_offset           = 32'(s_kept);
      token.kept_len             = 32'(len_kept);
      state_next.overlap_count   = state.overlap_count + ov_add;
      state_next.matched_count   = state.matched_count + len_kept;
      state_next.unmatched_count = state.unmatched_count + lit;
      // cursor saturates at the top of the position range
      state_next.cursor = end_pos[mte_pkg::POS_BITS] ? '1
                                                     : end_pos[mte_pkg::POS_BITS-1:0];
    end
  end

endmodule

// ----- rtl/match_token_emitter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// match_token_emitter
// turns sorted match records of one block into literal/match tokens
// ---------------------------------------------------------------------------
// path: a request enters the input register, then the token register
// throughput: one request per cycle unless the token output stalls; a request is
//   resolved as it moves from the input register into the token register
// reset: cursor and counters cleared, min_match_len back to 32, both
//   pipeline registers empty
module match_token_emitter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  mte_pkg::item_t                    item,
  output logic                              token_valid,
  input  logic                              token_ready,
  output mte_pkg::token_t                   token,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mte_pkg::MIN_LEN_BITS-1:0]  cfg_min_match_len
);

  logic [mte_pkg::MIN_LEN_BITS-1:0] min_len;
  logic                             held_valid;
  mte_pkg::item_t                   held;
  mte_pkg::state_t                  state;
  mte_pkg::state_t                  state_next;
  mte_pkg::token_t                  token_next;
  logic                             emit;
  logic                             advance;

  assign cfg_ready  = 1'b1;
  assign advance    = held_valid && (!token_valid || token_ready);
  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= mte_pkg::MIN_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_len <= cfg_min_match_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  mte_step u_step (
    .item       (held),
    .state      (state),
    .min_len    (min_len),
    .emit       (emit),
    .token      (token_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      token_valid <= 1'b0;
    end else if (advance) begin
      state       <= state_next;
      token_valid <= emit;
    end else if (token_ready) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      token <= token_next;
    end
  end

  // end of block leaves a clean state for the next block
  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    advance && held.mode == mte_pkg::MODE_BLOCK_END |=> state == '0)
    else $error("state not cleared after end of block");

  // a dropped match never shows a token
  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    advance && !emit |=> !token_valid)
    else $error("token raised for a dropped match");

  // match records only move the cursor forward
  a_cursor_fwd: assert property (@(posedge clk) disable iff (rst)
    advance && held.mode == mte_pkg::MODE_MATCH |=> state.cursor >= $past(state.cursor))
    else $error("cursor moved back on a match record");

  // input stalls only while a request is held
  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> held_valid && token_valid && !token_ready)
    else $error("request refused with room available");

endmodule

// ----- test/match_token_emitter_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// match_token_emitter_tb
// self-checking bench: match blocks, overlaps, short drops, block ends
// and min_match_len changes go through the valid/ready ports with random
// stalls on both sides, and every token is checked against a scoreboard
// ---------------------------------------------------------------------------
module match_token_emitter_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;

  class token_predictor;
    logic [mte_pkg::MIN_LEN_BITS-1:0] min_len;
    mte_pkg::pos_t   cursor;
    mte_pkg::pos_t   unmatched;
    mte_pkg::pos_t   matched;
    mte_pkg::pos_t   overlap;
    mte_pkg::token_t expected_tokens[$];
    int              fails;

    function new();
      min_len   = mte_pkg::MIN_LEN_RESET;
      cursor    = '0;
      unmatched = '0;
      matched   = '0;
      overlap   = '0;
      fails     = 0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void note_token(mte_pkg::token_t t);
      expected_tokens = {expected_tokens, t};
    endfunction

    function void take_request(mte_pkg::item_t r);
      mte_pkg::token_t           t;
      mte_pkg::pos_t             d;
      mte_pkg::pos_t             s;
      mte_pkg::pos_t             len;
      mte_pkg::pos_t             ov;
      mte_pkg::pos_t             lit;
      logic [mte_pkg::POS_BITS:0] stop;
      t = '0;
      if (r.mode == mte_pkg::MODE_BLOCK_END) begin
        lit = (r.block_len > cursor) ? r.block_len - cursor : '0;
        unmatched = unmatched + lit;
        t.is_block_end    = 1'b1;
        t.literal_start   = cursor;
        t.literal_len     = lit;
        t.block_unmatched = unmatched;
        t.block_matched   = matched;
        t.block_overlap   = overlap;
        cursor    = '0;
        unmatched = '0;
        matched   = '0;
        overlap   = '0;
        note_token(t);
        return;
      end
      d   = r.dest_pos;
      s   = r.src_pos;
      len = r.match_len;
      // front of the match already covered: trim it
      if (d < cursor) begin
        ov = cursor - d;
        if (ov >= len) begin
          overlap = overlap + len;
          return;
        end
        overlap = overlap + ov;
        len     = len - ov;
        d       = cursor;
        s       = s + ov;
      end
      if (len < mte_pkg::pos_t'(min_len)) begin
        overlap = overlap + len;
        return;
      end
      matched   = matched + len;
      lit       = d - cursor;
      unmatched = unmatched + lit;
      t.literal_start = cursor;
      t.literal_len   = lit;
      t.src_offset    = s;
      t.kept_len      = len;
      stop   = {1'b0, d} + {1'b0, len};
      cursor = stop[mte_pkg::POS_BITS] ? '1 : stop[mte_pkg::POS_BITS-1:0];
      note_token(t);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
        $error("%s: expected %h, got %h", name, exp_val, got_val);
        fails++;
      end
    endfunction

    function void check_token(mte_pkg::token_t got);
      mte_pkg::token_t exp_tok;
      if (expected_tokens.size() == 0) begin
        $error("token with nothing expected: %h", got);
        fails++;
        return;
      end
      exp_tok = expected_tokens.pop_front();
      compare_field("is_block_end", 32'(exp_tok.is_block_end), 32'(got.is_block_end));
      compare_field("literal_start", exp_tok.literal_start, got.literal_start);
      compare_field("literal_len", exp_tok.literal_len, got.literal_len);
      compare_field("src_offset", exp_tok.src_offset, got.src_offset);
      compare_field("kept_len", exp_tok.kept_len, got.kept_len);
      compare_field("block_unmatched", exp_tok.block_unmatched, got.block_unmatched);
      compare_field("block_matched", exp_tok.block_matched, got.block_matched);
      compare_field("block_overlap", exp_tok.block_overlap, got.block_overlap);
    endfunction
  endclass

  logic                             clk;
  logic                             rst               = 1'b1;
  logic                             item_valid        = 1'b0;
  logic                             item_ready;
  mte_pkg::item_t                   item              = '0;
  logic                             token_valid;
  logic                             token_ready       = 1'b0;
  mte_pkg::token_t                  token;
  logic                             cfg_valid         = 1'b0;
  logic                             cfg_ready;
  logic [mte_pkg::MIN_LEN_BITS-1:0] cfg_min_match_len = mte_pkg::MIN_LEN_RESET;

  token_predictor predictor;
  int             sender_idle_pct   = 0;
  int             receiver_idle_pct = 0;
  int             items_sent        = 0;
  int             cycle_count       = 0;

  match_token_emitter u_dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .item              (item),
    .token_valid       (token_valid),
    .token_ready       (token_ready),
    .token             (token),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_min_match_len (cfg_min_match_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[match_token_emitter] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    token_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && token_valid && token_ready) begin
      predictor.check_token(token);
    end
  end

  function automatic mte_pkg::item_t mk_match(mte_pkg::pos_t d, mte_pkg::pos_t s,
                                              mte_pkg::pos_t len, mte_pkg::pos_t blen);
    mte_pkg::item_t r;
    r           = '0;
    r.mode      = mte_pkg::MODE_MATCH;
    r.dest_pos  = d;
    r.src_pos   = s;
    r.match_len = len;
    r.block_len = blen;
    return r;
  endfunction

  // match fields are ignored on a block end, so fill them with ones
  function automatic mte_pkg::item_t mk_end(mte_pkg::pos_t blen);
    mte_pkg::item_t r;
    r           = '0;
    r.mode      = mte_pkg::MODE_BLOCK_END;
    r.dest_pos  = '1;
    r.src_pos   = '1;
    r.match_len = '1;
    r.block_len = blen;
    return r;
  endfunction

  // entered and left just after a falling edge
  task automatic send_request(input mte_pkg::item_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item       <= r;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predictor.take_request(r);
    items_sent++;
    @(negedge clk);
  endtask

  // dropped matches give no token, so let the pipeline drain as well
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (predictor.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_len(input logic [mte_pkg::MIN_LEN_BITS-1:0] v);
    cfg_valid         <= 1'b1;
    cfg_min_match_len <= v;
    do @(posedge clk); while (!cfg_ready);
    predictor.min_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_block(input int n_matches);
    mte_pkg::item_t  r;
    longint unsigned pos;
    longint unsigned dest;
    longint unsigned len;
    int              kind;
    for (int i = 0; i < n_matches; i++) begin
      pos         = predictor.cursor;
      kind        = $urandom_range(99);
      r           = '0;
      r.mode      = mte_pkg::MODE_MATCH;
      r.src_pos   = $urandom;
      r.block_len = $urandom;
      if (kind < 55) begin
        dest = pos + (($urandom_range(9) == 0) ? $urandom_range(0, 1 << 20)
                                               : $urandom_range(0, 24));
        len  = longint'(predictor.min_len) + $urandom_range(0, 43);
        len  = (len > 3) ? len - 3 : 0;
      end else if (kind < 80) begin
        // starts inside the covered region
        dest = (pos > 40) ? pos - $urandom_range(0, 40) : $urandom_range(0, int'(pos));
        len  = $urandom_range(0, 90);
      end else if (kind < 92) begin
        dest = $urandom;
        len  = $urandom_range(0, 300);
      end else begin
        dest = $urandom;
        len  = $urandom;
      end
      r.dest_pos  = dest[31:0];
      r.match_len = len[31:0];
      send_request(r);
    end
    r          = '0;
    r.mode     = mte_pkg::MODE_BLOCK_END;
    r.dest_pos = $urandom;
    r.src_pos  = $urandom;
    r.match_len = $urandom;
    pos  = predictor.cursor;
    kind = $urandom_range(99);
    if (kind < 70) begin
      pos = pos + $urandom_range(0, 60);
    end else if (kind < 85) begin
      pos = (pos > 20) ? pos - $urandom_range(0, 20) : 0;
    end else begin
      pos = $urandom;
    end
    r.block_len = pos[31:0];
    send_request(r);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int n_items);
    int                               target;
    logic [mte_pkg::MIN_LEN_BITS-1:0] v;
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      run_block($urandom_range(1, 12));
      if ($urandom_range(4) == 0) begin
        wait_idle();
        case ($urandom_range(5))
          0: v = '0;
          1: v = 8'd1;
          2: v = '1;
          default: v = mte_pkg::MIN_LEN_BITS'($urandom_range(2, 64));
        endcase
        write_min_len(v);
      end
    end
  endtask

  initial begin
    predictor = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_idle_pct   = 37;
    receiver_idle_pct = 85;
    // reset value of min_match_len still in force
    send_request(mk_match(32'd10, 32'd100, 32'd40, 32'd0));
    send_request(mk_match(32'd30, 32'd200, 32'd60, 32'd0));
    send_request(mk_match(32'd40, 32'd7, 32'd5, 32'd0));
    send_request(mk_match(32'd100, 32'd0, 32'd31, 32'd0));
    send_request(mk_match(32'd100, 32'd0, 32'd32, 32'd0));
    send_request(mk_end(32'd200));
    send_request(mk_match(32'd0, '1, '1, '1));
    // trimmed source wraps, cursor saturates at the top of the range
    send_request(mk_match(32'hFFFF_FFF0, '1, 32'h100, 32'd0));
    send_request(mk_end(32'd5));
    send_request(mk_end(32'd0));
    send_request(mk_end('1));

    wait_idle();
    write_min_len('0);
    send_request(mk_match(32'd5, 32'd9, 32'd0, 32'd0));
    send_request(mk_match(32'd5, 32'd9, 32'd0, 32'd0));
    send_request(mk_match(32'd3, 32'd1, 32'd2, 32'd0));
    send_request(mk_end(32'd5));

    wait_idle();
    write_min_len('1);
    send_request(mk_match(32'd0, 32'd0, 32'd254, 32'd0));
    send_request(mk_match(32'd0, 32'd0, 32'd255, 32'd0));
    send_request(mk_end(32'd300));

    wait_idle();
    write_min_len(8'd1);

    run_phase(37, 85, 340);
    run_phase(85, 37, 330);
    run_phase(0, 0, 330);

    wait_idle();
    if (predictor.fails == 0 && predictor.pending() == 0) begin
      $display("[match_token_emitter] OK");
    end else begin
      $display("[match_token_emitter] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mte_pkg.sv
rtl/mte_step.sv
rtl/match_token_emitter.sv
test/match_token_emitter_tb.sv
